// File: sv/dertlv_pkg.sv
// shared types and constants for the der tlv integer extractor
// beat structs for both channels, result kind codes, parameter defaults
// no dependencies
`default_nettype none

package dertlv_pkg;

	// parameter defaults
	localparam int MAX_LEN_OCTETS_DEF = 4;
	localparam int INT_BYTES_DEF      = 8;

	// result queue depth, must stay a power of two and at least 2
	localparam int QDEPTH = 4;

	localparam logic [3:0] WANTED_RESET = 4'd9;

	// result kinds
	localparam logic [2:0] KIND_INTEGER  = 3'd0;
	localparam logic [2:0] KIND_DONE_OK  = 3'd1;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd2;
	localparam logic [2:0] KIND_TOO_LONG = 3'd3;
	localparam logic [2:0] KIND_MISSING  = 3'd4;
	localparam logic [2:0] KIND_EXTRA    = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] int_value;
		logic [3:0]  int_index;
		logic [31:0] detail;
		logic        last;
	} result_t;

	// results produced by one parser step, first always goes out first
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

`default_nettype wire

// File: sv/dertlv_parser.sv
// tlv header parser and integer assembler, one byte per step
// holds all parser state; uses dertlv_pkg types and kind codes
`default_nettype none

module dertlv_parser #(
	parameter int MAX_LENGTH_OCTETS = dertlv_pkg::MAX_LEN_OCTETS_DEF,
	parameter int INTEGER_BYTES     = dertlv_pkg::INT_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire dertlv_pkg::in_beat_t beat,
	input  wire logic [3:0]         wanted,
	output dertlv_pkg::push_t       push
);
	import dertlv_pkg::*;

	typedef enum logic [6:0] {
		PH_TAG    = 7'b0000001,
		PH_LEN0   = 7'b0000010,
		PH_LENX   = 7'b0000100,
		PH_UNUSED = 7'b0001000,
		PH_INT    = 7'b0010000,
		PH_SKIP   = 7'b0100000,
		PH_HALT   = 7'b1000000
	} phase_t;

	localparam logic [7:0] TAG_INTEGER   = 8'h02;
	localparam logic [7:0] TAG_BITSTRING = 8'h03;
	localparam logic [7:0] TAG_NULL      = 8'h05;
	localparam logic [7:0] TAG_OID       = 8'h06;
	localparam logic [7:0] TAG_SEQUENCE  = 8'h30;

	phase_t      phase_q, phase_n;
	logic [7:0]  tag_q, tag_n;
	logic [2:0]  octs_q, octs_n;
	logic [31:0] remain_q, remain_n;
	logic        first_q, first_n;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  found_q, found_n;
	logic [31:0] surplus_q, surplus_n;

	logic        hdr;
	logic [31:0] hdr_len;
	logic [2:0]  cnt;
	logic [31:0] eff;
	logic [31:0] lenx_val;
	logic [2:0]  octs_dec;
	logic        p_valid, f_valid;
	result_t     p_res, f_res;
	logic [7:0]  b;

	assign b = beat.data_byte;

	always_comb begin
		phase_n   = phase_q;
		tag_n     = tag_q;
		octs_n    = octs_q;
		remain_n  = remain_q;
		first_n   = first_q;
		acc_n     = acc_q;
		found_n   = found_q;
		surplus_n = surplus_q;
		hdr       = 1'b0;
		hdr_len   = 32'd0;
		cnt       = 3'd0;
		eff       = remain_q;
		lenx_val  = {remain_q[23:0], b};
		octs_dec  = octs_q - 3'd1;
		p_valid   = 1'b0;
		p_res     = '0;
		f_valid   = 1'b0;
		f_res     = '0;

		unique case (phase_q)
			PH_TAG: begin
				if (found_q >= wanted) begin
					if (surplus_q != 32'hFFFF_FFFF)
						surplus_n = surplus_q + 32'd1;
				end else if (b == TAG_INTEGER || b == TAG_BITSTRING || b == TAG_NULL ||
						b == TAG_OID || b == TAG_SEQUENCE) begin
					tag_n    = b;
					remain_n = 32'd0;
					phase_n  = PH_LEN0;
				end else begin
					p_valid      = 1'b1;
					p_res.kind   = KIND_UNKNOWN;
					p_res.detail = {24'd0, b};
					phase_n      = PH_HALT;
				end
			end
			PH_LEN0: begin
				if (b[7]) begin
					// long form, octet count clamped
					if (b[6:0] > 7'(MAX_LENGTH_OCTETS))
						cnt = 3'(MAX_LENGTH_OCTETS);
					else
						cnt = b[2:0];
					remain_n = 32'd0;
					if (cnt == 3'd0) begin
						hdr     = 1'b1;
						hdr_len = 32'd0;
					end else begin
						octs_n  = cnt;
						phase_n = PH_LENX;
					end
				end else begin
					remain_n = {24'd0, b};
					hdr      = 1'b1;
					hdr_len  = {24'd0, b};
				end
			end
			PH_LENX: begin
				remain_n = lenx_val;
				octs_n   = octs_dec;
				if (octs_dec == 3'd0) begin
					hdr     = 1'b1;
					hdr_len = lenx_val;
				end
			end
			PH_UNUSED: begin
				phase_n = PH_TAG;
			end
			PH_INT: begin
				if (first_q && b == 8'd0)
					eff = remain_q - 32'd1;
				first_n  = 1'b0;
				remain_n = remain_q - 32'd1;
				if (first_q && eff > 32'(INTEGER_BYTES)) begin
					// oversized integer, flag it and skip the rest
					p_valid         = 1'b1;
					p_res.kind      = KIND_TOO_LONG;
					p_res.int_index = found_q;
					p_res.detail    = eff;
					if (found_q != 4'hF)
						found_n = found_q + 4'd1;
					phase_n = (remain_n != 32'd0) ? PH_SKIP : PH_TAG;
				end else begin
					// leading zero byte is dropped
					if (!(first_q && b == 8'd0))
						acc_n = {acc_q[55:0], b};
					if (remain_n == 32'd0) begin
						p_valid         = 1'b1;
						p_res.kind      = KIND_INTEGER;
						p_res.int_value = acc_n;
						p_res.int_index = found_q;
						if (found_q != 4'hF)
							found_n = found_q + 4'd1;
						phase_n = PH_TAG;
					end
				end
			end
			PH_SKIP: begin
				if (remain_q != 32'd0)
					remain_n = remain_q - 32'd1;
				if (remain_n == 32'd0)
					phase_n = PH_TAG;
			end
			PH_HALT: begin
			end
			default: begin
			end
		endcase

		// end of a tag/length header
		if (hdr) begin
			unique case (tag_q)
				TAG_INTEGER: begin
					acc_n   = 64'd0;
					first_n = 1'b1;
					if (hdr_len == 32'd0) begin
						p_valid         = 1'b1;
						p_res.kind      = KIND_INTEGER;
						p_res.int_value = 64'd0;
						p_res.int_index = found_q;
						if (found_q != 4'hF)
							found_n = found_q + 4'd1;
						phase_n = PH_TAG;
					end else begin
						phase_n = PH_INT;
					end
				end
				TAG_OID:       phase_n = (hdr_len != 32'd0) ? PH_SKIP : PH_TAG;
				TAG_BITSTRING: phase_n = PH_UNUSED;
				default:       phase_n = PH_TAG;
			endcase
		end

		// blob outcome at the last byte unless halted, then state returns to reset values
		if (beat.last_byte) begin
			if (phase_n != PH_HALT) begin
				f_valid    = 1'b1;
				f_res.last = 1'b1;
				if (found_n < wanted) begin
					f_res.kind   = KIND_MISSING;
					f_res.detail = {28'd0, wanted - found_n};
				end else if (surplus_n != 32'd0) begin
					f_res.kind   = KIND_EXTRA;
					f_res.detail = surplus_n;
				end else begin
					f_res.kind = KIND_DONE_OK;
				end
			end
			phase_n   = PH_TAG;
			tag_n     = 8'd0;
			octs_n    = 3'd0;
			remain_n  = 32'd0;
			first_n   = 1'b1;
			acc_n     = 64'd0;
			found_n   = 4'd0;
			surplus_n = 32'd0;
		end

		p_res.last = !f_valid;
	end

	always_comb begin
		push = '0;
		if (go) begin
			if (p_valid) begin
				push.first  = p_res;
				push.second = f_res;
				push.count  = f_valid ? 2'd2 : 2'd1;
			end else if (f_valid) begin
				push.first = f_res;
				push.count = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			tag_q     <= 8'd0;
			octs_q    <= 3'd0;
			remain_q  <= 32'd0;
			first_q   <= 1'b1;
			acc_q     <= 64'd0;
			found_q   <= 4'd0;
			surplus_q <= 32'd0;
		end else if (go) begin
			phase_q   <= phase_n;
			tag_q     <= tag_n;
			octs_q    <= octs_n;
			remain_q  <= remain_n;
			first_q   <= first_n;
			acc_q     <= acc_n;
			found_q   <= found_n;
			surplus_q <= surplus_n;
		end
	end

`ifndef ASSERT_OFF
	// last byte returns the counters to their reset values
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		go && beat.last_byte |=> found_q == 4'd0 && surplus_q == 32'd0 && phase_q == PH_TAG)
		else $error("parser state not cleared after last byte");

	// a halted blob produces nothing more
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		go && phase_q == PH_HALT |-> push.count == 2'd0)
		else $error("result produced after unknown tag");

	// of two results only the second carries last
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.second.last && !push.first.last)
		else $error("last flag misplaced in result pair");
`endif

endmodule

`default_nettype wire

// File: sv/dertlv_out_queue.sv
// small result queue between parser and result channel
// takes up to two results per cycle, hands out one per beat; uses dertlv_pkg
`default_nettype none

module dertlv_out_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dertlv_pkg::push_t push,
	output logic                   room,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output dertlv_pkg::result_t    res_beat
);
	import dertlv_pkg::*;

	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	result_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wp_q, rp_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                pop;

	assign res_valid = cnt_q != QCNT_W'(0);
	assign res_beat  = mem_q[rp_q];
	assign pop       = res_valid && !res_stall;
	// space for a full pair of results
	assign room      = cnt_q <= QCNT_W'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wp_q] <= push.first;
		if (push.count == 2'd2)
			mem_q[wp_q + QPTR_W'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPTR_W'(push.count);
			rp_q  <= rp_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(QCNT_W+1)'(cnt_q) + (QCNT_W+1)'(push.count) <= (QCNT_W+1)'(QDEPTH))
		else $error("result queue overflow");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.count == 2'd0 |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
		else $error("queue count wrong after pop");

	// a stalled result beat stays offered and unchanged
	a_stall_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_beat))
		else $error("stalled result beat changed");
`endif

endmodule

`default_nettype wire

// File: sv/der_tlv_integer_extractor.sv
// top level of the der tlv integer extractor
// byte input register, parser, result queue and the wanted-count register
// uses dertlv_pkg, dertlv_parser, dertlv_out_queue
//
// usage:
//   byte channel (byte_valid / byte_stall / byte_beat) carries one blob byte
//   per beat, last_byte set on the final byte of a blob
//   result channel (res_valid / res_stall / res_beat) carries one result per
//   beat: integers, error flags and the blob outcome, last set on the final
//   result caused by one input byte
//   cfg_we / cfg_wdata write the wanted integer count, only while idle
// timing:
//   an accepted byte is parsed from the input register once the queue can take
//   a pair; its results are written to the result queue and offered on res_beat
//   one byte per cycle sustained while the queue has room for a pair; a byte that
//   causes two results (integer plus blob outcome) costs two result beats, the
//   four-entry result queue takes up the difference
// stalls and reset:
//   res_stall holds results in the queue; once fewer than two entries are
//   free the parser holds the input register and byte_stall goes high
//   reset empties the queue and returns the parser to expecting a tag,
//   wanted count returns to 9
`default_nettype none

module der_tlv_integer_extractor #(
	parameter int MAX_LENGTH_OCTETS = dertlv_pkg::MAX_LEN_OCTETS_DEF,
	parameter int INTEGER_BYTES     = dertlv_pkg::INT_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// byte channel
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire dertlv_pkg::in_beat_t byte_beat,
	// result channel
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output dertlv_pkg::result_t       res_beat,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [3:0]           cfg_wdata
);
	import dertlv_pkg::*;

	in_beat_t   beat_s1;
	logic       vld_s1;
	logic [3:0] wanted_q;
	logic       room;
	logic       go;
	logic       accept;
	push_t      push;

	// the byte in the input register is parsed once the queue can take a pair
	assign go         = vld_s1 && room;
	assign byte_stall = vld_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			beat_s1 <= byte_beat;
	end

	// wanted integer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= WANTED_RESET;
		end else if (cfg_we) begin
			wanted_q <= cfg_wdata;
		end
	end

	dertlv_parser #(
		.MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
		.INTEGER_BYTES     (INTEGER_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.beat   (beat_s1),
		.wanted (wanted_q),
		.push   (push)
	);

	dertlv_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

`ifndef ASSERT_OFF
	// a held byte is never parsed twice or dropped
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |=> vld_s1)
		else $error("input register lost a stalled byte");

	// parsing only happens with a byte in the input register
	a_go_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> vld_s1 && room)
		else $error("results pushed without a byte or room");

	// an accepted byte is parsed before the next one lands
	a_one_deep: assert property (@(posedge clk) disable iff (!arst_n)
		accept && vld_s1 |-> go)
		else $error("input register overwritten");
`endif

endmodule

`default_nettype wire
